// File: rtl/cfr_pkg.sv
// Shared constants for the command frame receiver.
`default_nettype none
package cfr_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W      = $clog2(FRAME_BYTES);

    localparam logic [7:0]  CODE_STEER = 8'h02;
    localparam logic [7:0]  CODE_SPEED = 8'h03;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam int          CRC_SPAN   = 6;
    localparam int          CRC_STEPS  = CRC_SPAN * 8;
    localparam int          CRC_CNT_W  = $clog2(CRC_STEPS);

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_LIMIT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_ENABLE = 1'b1;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET      = 31'd500;

    localparam int OUT_DATA_W = 88;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CRC  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage
`default_nettype wire

// File: rtl/command_frame_receiver.sv
// Command frame receiver: byte store, bit-serial CRC-16/Modbus, steer/speed decode.
`default_nettype none
// Data words (tuser 0) are taken one per cycle while idle and stored at the running
// index; words past the frame length are dropped. An idle word (tuser 1) ends
// the frame and holds s_tready low through the run of the bit-serial CRC unit
// (one bit of frame bytes 0..5 per cycle) and the posting of the result, which is
// held off while the previous result still waits on the master side.
// A result sits in an output register, so new data words flow in while it waits.
module command_frame_receiver (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // data_byte
    input  wire  [0:0] s_tuser,   // command
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [cfr_pkg::OUT_DATA_W-1:0] m_tdata, // frame_code, steer_out, speed_out, crc_value
    output logic [0:0] m_tuser,   // crc_ok
    input  wire        cfg_wr_en,
    input  wire  [cfr_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  wire  [cfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    cfr_pkg::state_t state_reg, state_next;

    logic [7:0]                     frame_store_reg [cfr_pkg::FRAME_BYTES];
    logic [cfr_pkg::IDX_W-1:0]      byte_index_reg;
    logic [15:0]                    crc_reg, crc_next;
    logic [cfr_pkg::CRC_CNT_W-1:0]  crc_cnt_reg;
    logic signed [31:0]             steer_reg, steer_next;
    logic signed [31:0]             speed_reg, speed_next;
    logic [cfr_pkg::CFG_DATA_W-1:0] clamp_limit_reg;
    logic                           clamp_enable_reg;
    logic                           m_tvalid_reg;
    logic [cfr_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                           m_crc_ok_reg;

    logic        in_acc;
    logic        out_free;
    logic        crc_last;
    logic [7:0]  crc_byte;
    logic [15:0] crc_mix;
    logic [31:0] raw;
    logic signed [32:0] raw_ext, lim_pos, lim_neg, val_clamp;
    logic signed [31:0] val_load;
    logic [7:0]  code;

    assign s_tready = (state_reg == cfr_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign crc_last = (crc_cnt_reg == cfr_pkg::CRC_CNT_W'(cfr_pkg::CRC_STEPS - 1));
    assign code     = frame_store_reg[1];

    // one CRC bit per cycle; fold in the next byte at its first bit
    always_comb begin
        crc_byte = frame_store_reg[cfr_pkg::ADDR_W'(crc_cnt_reg >> 3)];
        crc_mix  = crc_reg;
        if (crc_cnt_reg[2:0] == 3'd0) begin
            crc_mix = crc_reg ^ {8'h00, crc_byte};
        end
        if (crc_mix[0]) begin
            crc_next = (crc_mix >> 1) ^ cfr_pkg::CRC_POLY;
        end else begin
            crc_next = crc_mix >> 1;
        end
    end

    always_comb begin
        raw       = {frame_store_reg[5], frame_store_reg[4],
                     frame_store_reg[3], frame_store_reg[2]};
        raw_ext   = $signed({raw[31], raw});
        lim_pos   = $signed({2'b00, clamp_limit_reg});
        lim_neg   = -lim_pos;
        val_clamp = raw_ext;
        if (clamp_enable_reg) begin
            if (raw_ext > lim_pos) begin
                val_clamp = lim_pos;
            end else if (raw_ext < lim_neg) begin
                val_clamp = lim_neg;
            end
        end
        val_load   = val_clamp[31:0];
        steer_next = steer_reg;
        speed_next = speed_reg;
        if (code == cfr_pkg::CODE_STEER) begin
            steer_next = val_load;
        end else if (code == cfr_pkg::CODE_SPEED) begin
            speed_next = val_load;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cfr_pkg::ST_IDLE: begin
                if (in_acc && s_tuser[0]) begin
                    state_next = cfr_pkg::ST_CRC;
                end
            end
            cfr_pkg::ST_CRC: begin
                if (crc_last) begin
                    state_next = cfr_pkg::ST_DONE;
                end
            end
            cfr_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = cfr_pkg::ST_IDLE;
                end
            end
            default: state_next = cfr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= cfr_pkg::ST_IDLE;
            byte_index_reg   <= '0;
            crc_cnt_reg      <= '0;
            crc_reg          <= cfr_pkg::CRC_INIT;
            steer_reg        <= '0;
            speed_reg        <= '0;
            clamp_limit_reg  <= cfr_pkg::LIMIT_RESET;
            clamp_enable_reg <= 1'b1;
            m_tvalid_reg     <= 1'b0;
            for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++) begin
                frame_store_reg[i] <= 8'h00;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                if (cfg_index == cfr_pkg::REG_CLAMP_LIMIT) begin
                    clamp_limit_reg <= cfg_wdata;
                end else if (cfg_index == cfr_pkg::REG_CLAMP_ENABLE) begin
                    clamp_enable_reg <= cfg_wdata[0];
                end
            end

            if (in_acc) begin
                if (s_tuser[0]) begin
                    byte_index_reg <= '0;
                    crc_cnt_reg    <= '0;
                    crc_reg        <= cfr_pkg::CRC_INIT;
                end else if (byte_index_reg < cfr_pkg::IDX_W'(cfr_pkg::FRAME_BYTES)) begin
                    frame_store_reg[byte_index_reg[cfr_pkg::ADDR_W-1:0]] <= s_tdata;
                    byte_index_reg <= byte_index_reg + 1'b1;
                end
            end

            if (state_reg == cfr_pkg::ST_CRC) begin
                crc_reg     <= crc_next;
                crc_cnt_reg <= crc_cnt_reg + 1'b1;
            end

            if (state_reg == cfr_pkg::ST_DONE && out_free) begin
                steer_reg    <= steer_next;
                speed_reg    <= speed_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cfr_pkg::ST_DONE && out_free) begin
            m_tdata_reg  <= {crc_reg, speed_next, steer_next, code};
            m_crc_ok_reg <= (crc_reg == {frame_store_reg[7], frame_store_reg[6]});
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_crc_ok_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg <= cfr_pkg::IDX_W'(cfr_pkg::FRAME_BYTES))
        else $error("byte index past frame length");

    a_idle_starts_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tuser[0]) |=> (state_reg == cfr_pkg::ST_CRC && byte_index_reg == '0
                                    && crc_cnt_reg == '0))
        else $error("idle word did not start CRC");

    a_crc_to_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cfr_pkg::ST_CRC && crc_last) |=> state_reg == cfr_pkg::ST_DONE)
        else $error("CRC run did not finish");

    a_done_posts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cfr_pkg::ST_DONE && out_free) |=> m_tvalid_reg)
        else $error("result not posted");

endmodule
`default_nettype wire

// File: sim/cfr_test_pkg.sv
// Word kinds and the frame CRC shared by the command frame receiver testbench.
`timescale 1ns / 1ps
package cfr_test_pkg;

    import cfr_pkg::*;

    typedef enum logic {
        WORD_DATA = 1'b0,
        WORD_IDLE = 1'b1
    } word_kind_t;

    // CRC-16/Modbus over six bytes, byte 0 in the low bits of span.
    function automatic logic [15:0] modbus_crc(input logic [8*CRC_SPAN-1:0] span);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int n = 0; n < CRC_SPAN; n++) begin
            crc = crc ^ {8'h00, span[8*n +: 8]};
            for (int b = 0; b < 8; b++) begin
                if (crc[0]) begin
                    crc = (crc >> 1) ^ CRC_POLY;
                end else begin
                    crc = crc >> 1;
                end
            end
        end
        return crc;
    endfunction

endpackage

// File: sim/command_frame_receiver_check.sv
// Checker for the command frame receiver: predicts each decoded frame and compares results.
`timescale 1ns / 1ps
module command_frame_receiver_check
    import cfr_pkg::*;
    import cfr_test_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    input  wire                   s_tready,
    input  wire [7:0]             s_tdata,
    input  wire [0:0]             s_tuser,
    input  wire                   m_tvalid,
    input  wire                   m_tready,
    input  wire [OUT_DATA_W-1:0]  m_tdata,
    input  wire [0:0]             m_tuser,
    input  wire                   cfg_wr_en,
    input  wire [CFG_ADDR_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [7:0]         code;
        logic signed [31:0] steer;
        logic signed [31:0] speed;
        logic               crc_ok;
        logic [15:0]        crc;
    } frame_result_t;

    frame_result_t       decoded_frames[$];
    logic [7:0]          store_bytes[FRAME_BYTES];
    int unsigned         write_pos;
    logic signed [31:0]  steer_q;
    logic signed [31:0]  speed_q;
    logic [CFG_DATA_W-1:0] limit_q;
    logic                enable_q;
    int                  errors;

    assign fail_count = errors;

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic signed [31:0] limit_value(input logic signed [31:0] raw);
        longint v;
        longint lim;
        v   = raw;
        lim = limit_q;
        if (enable_q) begin
            if (v > lim) begin
                v = lim;
            end else if (v < -lim) begin
                v = -lim;
            end
        end
        return v[31:0];
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        frame_result_t want;
        frame_result_t got;
        logic [8*CRC_SPAN-1:0] span;
        logic signed [31:0] value;
        if (!aresetn) begin
            for (int i = 0; i < FRAME_BYTES; i++) store_bytes[i] = 8'h00;
            write_pos = 0;
            steer_q   = 0;
            speed_q   = 0;
            limit_q   = LIMIT_RESET;
            enable_q  = 1'b1;
            decoded_frames.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CLAMP_LIMIT: limit_q = cfg_wdata;
                    REG_CLAMP_ENABLE: enable_q = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == WORD_DATA) begin
                    if (write_pos < FRAME_BYTES) begin
                        store_bytes[write_pos] = s_tdata;
                        write_pos++;
                    end
                end else begin
                    write_pos = 0;
                    for (int n = 0; n < CRC_SPAN; n++) span[8*n +: 8] = store_bytes[n];
                    value = {store_bytes[5], store_bytes[4], store_bytes[3], store_bytes[2]};
                    if (store_bytes[1] == CODE_STEER) begin
                        steer_q = limit_value(value);
                    end else if (store_bytes[1] == CODE_SPEED) begin
                        speed_q = limit_value(value);
                    end
                    want.code   = store_bytes[1];
                    want.steer  = steer_q;
                    want.speed  = speed_q;
                    want.crc    = modbus_crc(span);
                    want.crc_ok = (want.crc == {store_bytes[7], store_bytes[6]});
                    decoded_frames.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                got.code   = m_tdata[7:0];
                got.steer  = m_tdata[39:8];
                got.speed  = m_tdata[71:40];
                got.crc    = m_tdata[87:72];
                got.crc_ok = m_tuser[0];
                if (decoded_frames.size() == 0) begin
                    report_mismatch("unexpected result", got.code, 0);
                end else begin
                    want = decoded_frames.pop_front();
                    if (got.code !== want.code) report_mismatch("frame_code", got.code, want.code);
                    if (got.steer !== want.steer) report_mismatch("steer_out", got.steer, want.steer);
                    if (got.speed !== want.speed) report_mismatch("speed_out", got.speed, want.speed);
                    if (got.crc_ok !== want.crc_ok) report_mismatch("crc_ok", got.crc_ok, want.crc_ok);
                    if (got.crc !== want.crc) report_mismatch("crc_value", got.crc, want.crc);
                end
            end
        end
        pending <= decoded_frames.size();
    end

endmodule

// File: sim/command_frame_receiver_test.sv
// Testbench top for the command frame receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module command_frame_receiver_test;

    import cfr_pkg::*;
    import cfr_test_pkg::*;

    localparam int PHASES       = 5;
    localparam int PHASE_WORDS  = 230;
    localparam int SETTLE_TICKS = 60;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending;

    bit                    calm;
    int                    words_sent;
    int                    stall_left;
    logic [CFG_DATA_W-1:0] cur_limit;

    command_frame_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    command_frame_receiver_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(input word_kind_t kind, input logic [7:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    // Send len data words of a frame (positions past the store get random bytes), then idle.
    task automatic send_frame(input logic [7:0] lead, input logic [7:0] code,
                              input logic [31:0] value, input bit good_crc, input int len);
        logic [7:0]  fb[FRAME_BYTES];
        logic [15:0] crc;
        fb[0] = lead;
        fb[1] = code;
        fb[2] = value[7:0];
        fb[3] = value[15:8];
        fb[4] = value[23:16];
        fb[5] = value[31:24];
        crc = modbus_crc({fb[5], fb[4], fb[3], fb[2], fb[1], fb[0]});
        if (!good_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        fb[6] = crc[7:0];
        fb[7] = crc[15:8];
        for (int i = 0; i < len; i++) begin
            send_word(WORD_DATA, (i < FRAME_BYTES) ? fb[i] : 8'($urandom));
        end
        send_word(WORD_IDLE, 8'($urandom));
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] lim;
        lim = {1'b0, cur_limit};
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return lim;
            2: return lim + 1;
            3: return -lim;
            4: return -lim - 1;
            5: return $urandom_range(0, 2000) - 1000;
            6: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(0, 1) ? CODE_STEER : CODE_SPEED;
        end
        return 8'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic random_traffic(input int word_goal);
        int r;
        while (words_sent < word_goal) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_frame(8'($urandom), pick_code(), pick_value(),
                           $urandom_range(0, 7) != 0, FRAME_BYTES);
            end else if (r < 85) begin
                send_frame(8'($urandom), pick_code(), pick_value(), 1'b1,
                           $urandom_range(0, FRAME_BYTES - 1));
            end else if (r < 95) begin
                send_frame(8'($urandom), pick_code(), pick_value(), 1'b1,
                           $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 4));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(word_kind_t'($urandom_range(0, 1)), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("command_frame_receiver_test NOT OK");
        $finish;
    end

    initial begin
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tuser    <= WORD_DATA;
        m_tready   <= 1'b0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= REG_CLAMP_LIMIT;
        cfg_wdata  <= '0;
        calm       = 1'b0;
        words_sent = 0;
        stall_left = 0;
        cur_limit  = LIMIT_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty frame on reset state, clamped steer, bad-CRC speed, short frame on stale bytes.
        send_word(WORD_IDLE, 8'hFF);
        send_frame(8'hA5, CODE_STEER, 32'h7FFF_FFFF, 1'b1, FRAME_BYTES);
        send_frame(8'h5A, CODE_SPEED, 32'h8000_0000, 1'b0, FRAME_BYTES);
        send_frame(8'hFF, CODE_STEER, 32'h0000_0000, 1'b1, 3);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: cur_limit = '0;
                    2: cur_limit = 31'h7FFF_FFFF;
                    3: cur_limit = 31'($urandom);
                    default: cur_limit = 31'($urandom_range(1, 100000));
                endcase
                write_reg(REG_CLAMP_LIMIT, cur_limit);
                write_reg(REG_CLAMP_ENABLE, (phase == 3) ? '0 : 31'd1);
            end
            if (phase == PHASES - 1) calm = 1'b1;
            random_traffic(words_sent + PHASE_WORDS);
        end

        drain();
        if (fail_count == 0) begin
            $display("command_frame_receiver_test OK");
        end else begin
            $display("command_frame_receiver_test NOT OK");
        end
        $finish;
    end

endmodule
